// File: hw/rtl/cnti_pkg.sv
// Shared types, constants and helper functions of the numeral parser.
package cnti_pkg;

  // Default depth of the token store
  localparam int MAX_TOKENS_DEF = 16;

  localparam int VALUE_W  = 54;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 4;
  localparam int ADDEND_W = 10;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

  // Token codes of the two units
  localparam logic [CODE_W-1:0] CODE_TEN  = 4'd10;
  localparam logic [CODE_W-1:0] CODE_HUND = 4'd11;

  // Pending unit during the right-to-left walk
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_TEN  = 2'd1;
  localparam logic [1:0] PEND_HUND = 2'd2;

  // UTF-8 byte sequences of zero..nine, ten, hundred
  localparam logic [23:0] NUMERAL_SEQ [12] = '{
    24'hE99BB6, 24'hE4B880, 24'hE4BA8C, 24'hE4B889, 24'hE59B9B, 24'hE4BA94,
    24'hE585AD, 24'hE4B883, 24'hE585AB, 24'hE4B99D, 24'hE58D81, 24'hE799BE
  };

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } match_t;

  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] code;
  } tok_wr_t;

  typedef struct packed {
    logic unit_seen;
    logic too_long;
  } scan_flags_t;

  // Look up a three-byte sequence in the numeral table
  function automatic match_t match_numeral(input logic [23:0] seq);
    match_t m;
    m.hit  = 1'b0;
    m.code = '0;
    for (int k = 0; k < 12; k++) begin
      if (seq == NUMERAL_SEQ[k]) begin
        m.hit  = 1'b1;
        m.code = CODE_W'(k);
      end
    end
    return m;
  endfunction

  // Amount one walk step adds, given the pending unit and the token
  function automatic logic [ADDEND_W-1:0] walk_addend(input logic [1:0] pend,
                                                     input logic [CODE_W-1:0] tok);
    logic [ADDEND_W-1:0] scale;
    logic [ADDEND_W-1:0] r;
    scale = (pend == PEND_TEN) ? ADDEND_W'(10) : ADDEND_W'(100);
    if (pend == PEND_NONE) begin
      r = (tok < CODE_TEN) ? ADDEND_W'(tok) : '0;
    end else if (tok < CODE_TEN) begin
      r = ADDEND_W'(tok) * scale;
    end else begin
      r = scale;
    end
    return r;
  endfunction

  // Pending unit left behind by a token
  function automatic logic [1:0] walk_pending(input logic [CODE_W-1:0] tok);
    logic [1:0] p;
    case (tok)
      CODE_TEN:  p = PEND_TEN;
      CODE_HUND: p = PEND_HUND;
      default:   p = PEND_NONE;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/cnti_if.sv
// Valid/ready channel interfaces for string bytes and parse results.
interface cnti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface cnti_out_if;
  logic                          valid;
  logic                          ready;
  logic [cnti_pkg::VALUE_W-1:0]  value;
  logic [cnti_pkg::STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// File: hw/rtl/chinese_numeral_to_integer_top.sv
// Top level of the numeral parser: scanner, token store and walk sequencer.
// Bytes are taken one per cycle while scanning. After the last byte of a
// string the block holds ready low while one shared adder steps through the
// stored run, one token per cycle from the token store's single read port:
// a run that holds a ten or hundred ends with a step that adds any unit left
// pending, and a string with no numeral or with a run too long goes straight
// to the output register. The result then waits in the output register until
// taken, and the next string starts the cycle after. Runs beyond MAX_TOKENS
// tokens report status 2.
module chinese_numeral_to_integer_top #(
  parameter int MAX_TOKENS = cnti_pkg::MAX_TOKENS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cnti_in_if.sink           in_ch,
  cnti_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_TOKENS);
  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam int VW = cnti_pkg::VALUE_W;

  typedef enum logic [3:0] {
    ST_SCAN = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                         state_r;
  logic                           acc;
  cnti_pkg::tok_wr_t              wr;
  logic [AW-1:0]                  wr_addr;
  logic [CW-1:0]                  count_nxt;
  cnti_pkg::scan_flags_t          flags_nxt;
  logic [cnti_pkg::CODE_W-1:0]    rd_tok;
  logic                           walk_r;
  logic [AW-1:0]                  iss_idx_r;
  logic [CW-1:0]                  iss_left_r;
  logic [CW-1:0]                  proc_left_r;
  logic                           rd_vld_r;
  logic [VW-1:0]                  acc_r;
  logic [1:0]                     pend_r;
  logic [VW-1:0]                  value_r;
  logic [cnti_pkg::STATUS_W-1:0]  status_r;
  logic [cnti_pkg::ADDEND_W-1:0]  addend;
  logic                           mul10;
  logic [VW-1:0]                  sum;

  assign in_ch.ready   = (state_r == ST_SCAN);
  assign acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = (state_r == ST_OUT);
  assign out_ch.value  = value_r;
  assign out_ch.status = status_r;

  cnti_scan #(.MAX_TOKENS(MAX_TOKENS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .char_byte (in_ch.char_byte),
    .last_byte (in_ch.last_byte),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .count_nxt (count_nxt),
    .flags_nxt (flags_nxt)
  );

  cnti_tok_mem #(.DEPTH(MAX_TOKENS)) u_mem (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr_addr),
    .wdata   (wr.code),
    .raddr   (iss_idx_r),
    .rdata_r (rd_tok)
  );

  // Select the operands of the shared unit
  always_comb begin
    if (state_r == ST_FIN) begin
      addend = cnti_pkg::walk_addend(pend_r, cnti_pkg::CODE_TEN);
      mul10  = 1'b0;
    end else if (walk_r) begin
      addend = cnti_pkg::walk_addend(pend_r, rd_tok);
      mul10  = 1'b0;
    end else begin
      addend = cnti_pkg::ADDEND_W'(rd_tok);
      mul10  = 1'b1;
    end
  end

  cnti_alu u_alu (
    .acc    (acc_r),
    .addend (addend),
    .mul10  (mul10),
    .sat    (mul10),
    .sum    (sum)
  );

  // Sequence the scan, the token walk and the result handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SCAN;
      walk_r      <= 1'b0;
      iss_idx_r   <= '0;
      iss_left_r  <= '0;
      proc_left_r <= '0;
      rd_vld_r    <= 1'b0;
      acc_r       <= '0;
      pend_r      <= cnti_pkg::PEND_NONE;
    end else begin
      case (state_r)
        ST_SCAN: begin
          if (acc && in_ch.last_byte) begin
            if (count_nxt == '0) begin
              value_r  <= '0;
              status_r <= cnti_pkg::STATUS_NONE;
              state_r  <= ST_OUT;
            end else if (flags_nxt.too_long) begin
              value_r  <= '0;
              status_r <= cnti_pkg::STATUS_LONG;
              state_r  <= ST_OUT;
            end else begin
              walk_r      <= flags_nxt.unit_seen;
              iss_idx_r   <= flags_nxt.unit_seen ? AW'(count_nxt - CW'(1)) : '0;
              iss_left_r  <= count_nxt;
              proc_left_r <= count_nxt;
              rd_vld_r    <= 1'b0;
              acc_r       <= '0;
              pend_r      <= cnti_pkg::PEND_NONE;
              state_r     <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // Issue the next read
          if (iss_left_r != '0) begin
            rd_vld_r   <= 1'b1;
            iss_left_r <= iss_left_r - CW'(1);
            iss_idx_r  <= walk_r ? iss_idx_r - AW'(1) : iss_idx_r + AW'(1);
          end else begin
            rd_vld_r <= 1'b0;
          end
          // Fold in the token read last cycle
          if (rd_vld_r) begin
            acc_r       <= sum;
            pend_r      <= cnti_pkg::walk_pending(rd_tok);
            proc_left_r <= proc_left_r - CW'(1);
            if (proc_left_r == CW'(1)) begin
              if (walk_r) begin
                state_r <= ST_FIN;
              end else begin
                value_r  <= sum;
                status_r <= cnti_pkg::STATUS_OK;
                state_r  <= ST_OUT;
              end
            end
          end
        end
        ST_FIN: begin
          // Add a unit left pending at the start of the run
          value_r  <= sum;
          status_r <= cnti_pkg::STATUS_OK;
          state_r  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            state_r <= ST_SCAN;
          end
        end
        default: state_r <= ST_SCAN;
      endcase
    end
  end

endmodule

// File: hw/rtl/cnti_tok_mem.sv
// Token store: one write port, one registered read port.
module cnti_tok_mem #(
  parameter int DEPTH = cnti_pkg::MAX_TOKENS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [cnti_pkg::CODE_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [cnti_pkg::CODE_W-1:0] rdata_r
);

  logic [cnti_pkg::CODE_W-1:0] mem [DEPTH];

  // Write a token code
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// File: hw/rtl/cnti_scan.sv
// Byte scanner: finds the numeral run and writes its tokens to the store.
module cnti_scan #(
  parameter int MAX_TOKENS = cnti_pkg::MAX_TOKENS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               acc,
  input  logic [7:0]                         char_byte,
  input  logic                               last_byte,
  output cnti_pkg::tok_wr_t                  wr,
  output logic [$clog2(MAX_TOKENS)-1:0]      wr_addr,
  output logic [$clog2(MAX_TOKENS+1)-1:0]    count_nxt,
  output cnti_pkg::scan_flags_t              flags_nxt
);

  localparam int AW = $clog2(MAX_TOKENS);
  localparam int CW = $clog2(MAX_TOKENS + 1);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_RUN    = 3'b010,
    PH_END    = 3'b100
  } phase_t;

  logic [15:0]          window_r;
  phase_t               phase_r, phase_nxt;
  logic [1:0]           off_r, off_nxt;
  logic [CW-1:0]        count_r;
  cnti_pkg::scan_flags_t flags_r;
  logic [23:0]          seq;
  cnti_pkg::match_t     m;
  logic                 add;
  logic                 room;

  assign seq  = {window_r, char_byte};
  assign m    = cnti_pkg::match_numeral(seq);
  assign room = (count_r < CW'(MAX_TOKENS));

  // Advance the scan phase and token bookkeeping for this byte
  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    count_nxt = count_r;
    flags_nxt = flags_r;
    add       = 1'b0;
    if (phase_r != PH_END && char_byte == 8'h00) begin
      phase_nxt = PH_END;
    end else begin
      case (phase_r)
        PH_SEARCH: begin
          if (m.hit) begin
            add       = 1'b1;
            phase_nxt = PH_RUN;
            off_nxt   = 2'd0;
          end
        end
        PH_RUN: begin
          if (off_r >= 2'd2) begin
            if (m.hit) begin
              add     = 1'b1;
              off_nxt = 2'd0;
            end else begin
              phase_nxt = PH_END;
            end
          end else begin
            off_nxt = off_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
    if (add) begin
      if (m.code >= cnti_pkg::CODE_TEN) begin
        flags_nxt.unit_seen = 1'b1;
      end
      if (room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        flags_nxt.too_long = 1'b1;
      end
    end
  end

  assign wr.en   = acc && add && room;
  assign wr.code = m.code;
  assign wr_addr = count_r[AW-1:0];

  // Update on each accepted byte; drop everything after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      phase_r  <= PH_SEARCH;
      off_r    <= '0;
      count_r  <= '0;
      flags_r  <= '0;
    end else if (acc) begin
      if (last_byte) begin
        window_r <= '0;
        phase_r  <= PH_SEARCH;
        off_r    <= '0;
        count_r  <= '0;
        flags_r  <= '0;
      end else begin
        window_r <= seq[15:0];
        phase_r  <= phase_nxt;
        off_r    <= off_nxt;
        count_r  <= count_nxt;
        flags_r  <= flags_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/cnti_alu.sv
// Shared accumulate unit: acc or acc*10, plus a small addend, optional saturation.
module cnti_alu (
  input  logic [cnti_pkg::VALUE_W-1:0]  acc,
  input  logic [cnti_pkg::ADDEND_W-1:0] addend,
  input  logic                          mul10,
  input  logic                          sat,
  output logic [cnti_pkg::VALUE_W-1:0]  sum
);

  localparam int VW = cnti_pkg::VALUE_W;
  localparam int SW = VW + 4;

  logic [SW-1:0] base;
  logic [SW-1:0] total;

  // Scale by ten with shifts, then add
  assign base  = mul10 ? (({4'b0, acc} << 3) + ({4'b0, acc} << 1)) : {4'b0, acc};
  assign total = base + SW'(addend);

  // Clamp to the value range when saturating
  assign sum = (sat && total[SW-1:VW] != '0) ? '1 : total[VW-1:0];

endmodule

// File: hw/rtl/cnti_chk.sv
// Port-level checker for the numeral parser, bound to the top level.
module cnti_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cnti_pkg::VALUE_W-1:0]  out_value,
  input logic [cnti_pkg::STATUS_W-1:0] out_status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cnti_pkg::STATUS_OK |-> out_value == '0)
    else $error("error result with nonzero value");

  // Take no byte while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Stop taking bytes after the end of a string
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("byte taken right after string end");

  // Return to scanning once the result is taken
  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("no return to scanning after result");

endmodule

bind chinese_numeral_to_integer_top cnti_chk u_cnti_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_byte),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);

// File: sim/chinese_numeral_to_integer_top_test.sv
// Testbench for the numeral parser: random byte strings, in-bench predictor, result checks.
module chinese_numeral_to_integer_top_test;

  localparam int RUN_DEPTH = cnti_pkg::MAX_TOKENS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1800;
  localparam logic [63:0] VALUE_CAP = (64'd1 << cnti_pkg::VALUE_W) - 64'd1;

  typedef enum logic [2:0] {
    SCAN_SEEK = 3'b001,
    SCAN_RUN  = 3'b010,
    SCAN_DONE = 3'b100
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } string_byte_t;

  typedef struct packed {
    logic [cnti_pkg::VALUE_W-1:0]  value;
    logic [cnti_pkg::STATUS_W-1:0] status;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cnti_in_if  in_ch ();
  cnti_out_if out_ch ();

  chinese_numeral_to_integer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  string_byte_t  pending_bytes[$];
  parse_result_t awaited_results[$];
  logic [7:0]    string_buf[$];

  int  fault_count = 0;
  int  cycle_count = 0;
  int  send_idle = 0;
  int  take_idle = 0;
  bit  calm = 1'b0;

  // Predictor state of the scanner
  logic [15:0]                 win = '0;
  scan_phase_t                 phase = SCAN_SEEK;
  int                          offs = 0;
  logic [cnti_pkg::CODE_W-1:0] run_tokens[RUN_DEPTH];
  int                          tok_count = 0;
  bit                          has_unit = 1'b0;
  bit                          overflow = 1'b0;
  logic [63:0]                 digit_value = '0;

  // Return the numeral code of a three-byte sequence, or -1
  function automatic int numeral_code(input logic [23:0] seq);
    int hit;
    hit = -1;
    for (int k = 0; k < 12; k++) begin
      if (seq == cnti_pkg::NUMERAL_SEQ[k]) hit = k;
    end
    return hit;
  endfunction

  // Pick an idle length: mostly none, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Append one token to the run and update the decimal reading
  task automatic keep_token(input int code);
    if (code >= cnti_pkg::CODE_TEN) begin
      has_unit = 1'b1;
    end else if (digit_value > (VALUE_CAP - code) / 10) begin
      digit_value = VALUE_CAP;
    end else begin
      digit_value = digit_value * 10 + code;
    end
    if (tok_count < RUN_DEPTH) begin
      run_tokens[tok_count] = cnti_pkg::CODE_W'(code);
      tok_count++;
    end else begin
      overflow = 1'b1;
    end
  endtask

  // Advance the predictor by one accepted byte; queue the result at string end
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [23:0]   seq;
    int            code;
    int            i;
    parse_result_t res;
    logic [63:0]   sum;
    logic [63:0]   scale;
    logic [1:0]    pend;
    logic [3:0]    t;
    seq = {win, b};
    if (phase != SCAN_DONE && b == 8'h00) begin
      phase = SCAN_DONE;
    end else if (phase == SCAN_SEEK) begin
      code = numeral_code(seq);
      if (code >= 0) begin
        keep_token(code);
        phase = SCAN_RUN;
        offs = 0;
      end
    end else if (phase == SCAN_RUN) begin
      if (offs >= 2) begin
        code = numeral_code(seq);
        if (code >= 0) begin
          keep_token(code);
          offs = 0;
        end else begin
          phase = SCAN_DONE;
        end
      end else begin
        offs++;
      end
    end
    win = seq[15:0];
    if (!last) return;

    if (tok_count == 0) begin
      res.value = '0;
      res.status = cnti_pkg::STATUS_NONE;
    end else if (overflow) begin
      res.value = '0;
      res.status = cnti_pkg::STATUS_LONG;
    end else if (!has_unit) begin
      res.value = digit_value[cnti_pkg::VALUE_W-1:0];
      res.status = cnti_pkg::STATUS_OK;
    end else begin
      // Walk the run from right to left; a pending unit scales the next digit
      sum = '0;
      pend = cnti_pkg::PEND_NONE;
      for (i = tok_count; i > 0; i--) begin
        t = run_tokens[i-1];
        if (pend == cnti_pkg::PEND_NONE) begin
          if (t < cnti_pkg::CODE_TEN) sum += t;
          else pend = (t == cnti_pkg::CODE_TEN) ? cnti_pkg::PEND_TEN : cnti_pkg::PEND_HUND;
        end else begin
          scale = (pend == cnti_pkg::PEND_TEN) ? 64'd10 : 64'd100;
          if (t < cnti_pkg::CODE_TEN) begin
            sum += t * scale;
            pend = cnti_pkg::PEND_NONE;
          end else begin
            sum += scale;
            pend = (t == cnti_pkg::CODE_TEN) ? cnti_pkg::PEND_TEN : cnti_pkg::PEND_HUND;
          end
        end
      end
      if (pend == cnti_pkg::PEND_TEN) sum += 64'd10;
      else if (pend == cnti_pkg::PEND_HUND) sum += 64'd100;
      res.value = sum[cnti_pkg::VALUE_W-1:0];
      res.status = cnti_pkg::STATUS_OK;
    end
    awaited_results.push_back(res);

    // Clear the scanner for the next string
    win = '0;
    phase = SCAN_SEEK;
    offs = 0;
    tok_count = 0;
    has_unit = 1'b0;
    overflow = 1'b0;
    digit_value = '0;
  endtask

  // Add the three bytes of a numeral to the string being built
  task automatic put_numeral(input int code);
    logic [23:0] seq;
    seq = cnti_pkg::NUMERAL_SEQ[code];
    string_buf.push_back(seq[23:16]);
    string_buf.push_back(seq[15:8]);
    string_buf.push_back(seq[7:0]);
  endtask

  // Move the built string into the request queue, flagging its final byte
  task automatic queue_string();
    string_byte_t sb;
    for (int i = 0; i < string_buf.size(); i++) begin
      sb.char_byte = string_buf[i];
      sb.last_byte = (i == string_buf.size() - 1);
      pending_bytes.push_back(sb);
    end
    string_buf.delete();
  endtask

  // Count cycles, switch between calm and noisy stretches, enforce the limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ($urandom_range(0, 249) == 0) calm <= ~calm;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drive string bytes from the request queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.char_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_byte(in_ch.char_byte, in_ch.last_byte);
        void'(pending_bytes.pop_front());
      end
      // Hold a request that is still waiting for ready
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_idle > 0) begin
          send_idle--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.char_byte <= pending_bytes[0].char_byte;
          in_ch.last_byte <= pending_bytes[0].last_byte;
          send_idle = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Take results, stall at random, compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected result: value %0d status %0d", out_ch.value, out_ch.status);
          fault_count++;
        end else begin
          if (out_ch.value !== awaited_results[0].value ||
              out_ch.status !== awaited_results[0].status) begin
            if (fault_count < 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       awaited_results[0].value, awaited_results[0].status,
                       out_ch.value, out_ch.status);
            fault_count++;
          end
          void'(awaited_results.pop_front());
        end
      end
      if (take_idle > 0) begin
        take_idle--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        take_idle = pick_gap();
      end
    end
  end

  initial begin
    int          random_bytes;
    int          run_len;
    int          code;
    int          n;
    int          r;
    int          twist;
    int          pick;
    bit          digits_only;
    bit          all_nines;
    logic [23:0] seq;

    // Directed: no numeral, lone zero byte, units, zero digit, zero before a
    // numeral, token cut off at the end, trailing junk after a digit
    string_buf.push_back(8'h41);
    queue_string();
    string_buf.push_back(8'h00);
    queue_string();
    put_numeral(int'(cnti_pkg::CODE_TEN));
    queue_string();
    put_numeral(int'(cnti_pkg::CODE_HUND));
    put_numeral(2);
    queue_string();
    put_numeral(0);
    queue_string();
    string_buf.push_back(8'h00);
    put_numeral(1);
    queue_string();
    string_buf.push_back(8'hE4);
    string_buf.push_back(8'hB9);
    queue_string();
    put_numeral(7);
    string_buf.push_back(8'hFF);
    queue_string();

    // Random strings: mostly numeral runs with random content, some noise
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        n = $urandom_range(0, 3);
        repeat (n) string_buf.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 5) run_len = $urandom_range(RUN_DEPTH + 1, RUN_DEPTH + 3);
        else if (r < 15) run_len = $urandom_range(10, RUN_DEPTH);
        else run_len = $urandom_range(1, 6);
        digits_only = ($urandom_range(0, 2) == 0);
        all_nines = ($urandom_range(0, 39) == 0);
        if (all_nines) run_len = RUN_DEPTH;
        twist = $urandom_range(0, 99);
        for (int i = 0; i < run_len; i++) begin
          // Cut the run with a zero byte
          if (twist < 5 && i == run_len / 2) string_buf.push_back(8'h00);
          if (all_nines) code = 9;
          else if (!digits_only && $urandom_range(0, 2) == 0)
            code = $urandom_range(cnti_pkg::CODE_TEN, cnti_pkg::CODE_HUND);
          else code = $urandom_range(0, 9);
          put_numeral(code);
        end
        n = $urandom_range(0, 3);
        repeat (n) string_buf.push_back(8'($urandom));
        // End on a token cut short
        if (twist >= 88) begin
          seq = cnti_pkg::NUMERAL_SEQ[$urandom_range(0, 11)];
          string_buf.push_back(seq[23:16]);
          if ($urandom_range(0, 1) == 1) string_buf.push_back(seq[15:8]);
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            seq = cnti_pkg::NUMERAL_SEQ[$urandom_range(0, 11)];
            pick = $urandom_range(0, 2);
            string_buf.push_back(seq[8*pick +: 8]);
          end else begin
            string_buf.push_back(8'($urandom));
          end
        end
      end
      random_bytes += string_buf.size();
      queue_string();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes accepted and every prediction compared against a result
    while (pending_bytes.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: chinese_numeral_to_integer_top.f
hw/rtl/cnti_pkg.sv
hw/rtl/cnti_if.sv
hw/rtl/cnti_tok_mem.sv
hw/rtl/cnti_scan.sv
hw/rtl/cnti_alu.sv
hw/rtl/chinese_numeral_to_integer_top.sv
hw/rtl/cnti_chk.sv
sim/chinese_numeral_to_integer_top_test.sv
